// ===== src/erle_pkg.sv =====
// shared constants and types for the escape run-length expander
package erle_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int REM_W   = 3;

    localparam logic [BYTE_W-1:0] ESC_CHAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_ONE  = 8'h31;
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;

    typedef struct packed {
        logic               pass;
        logic               escape;
        logic [COUNT_W-1:0] copies;
    } class_t;

endpackage

// ===== src/erle_classify.sv =====
// byte classifier: pass-through, escape open, or repeat count from a digit
module erle_classify (
    input  logic [erle_pkg::BYTE_W-1:0] in_byte,
    input  logic                        pending,
    output erle_pkg::class_t            cls
);

    logic                         is_digit;
    logic [erle_pkg::BYTE_W-1:0]  digit_val;

    assign is_digit  = (in_byte >= erle_pkg::DIGIT_ONE) && (in_byte <= erle_pkg::DIGIT_NINE);
    assign digit_val = in_byte - erle_pkg::DIGIT_ZERO;

    always_comb begin
        cls.pass   = 1'b0;
        cls.escape = 1'b0;
        cls.copies = '0;
        if (pending) begin
            if (is_digit) begin
                cls.copies = digit_val[erle_pkg::COUNT_W-1:0] - erle_pkg::COUNT_W'(1);
            end
        end else if (in_byte == erle_pkg::ESC_CHAR) begin
            cls.escape = 1'b1;
        end else begin
            cls.pass = 1'b1;
        end
    end

endmodule

// ===== src/escape_run_length_expander.sv =====
// top level of the escape run-length expander
// A plain byte yields one output transfer. A '*' yields nothing. A digit d after it yields
// d-1 copies (at most eight) of the byte before the '*', one per cycle while the output is
// not stalled, from a single output register driven by a down-counter; the input is not
// ready until the run has drained. A byte marked tlast adds one terminator transfer
// (tdata 0, tuser 1) after its own results and returns the block to its reset state.
module escape_run_length_expander (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // last_of_run
    output logic       m_tuser    // end_of_string
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_TERM = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [erle_pkg::BYTE_W-1:0]    prev_reg, prev_next;
    logic                           pend_reg, pend_next;
    logic [erle_pkg::BYTE_W-1:0]    copy_reg, copy_next;
    logic [erle_pkg::REM_W-1:0]     cnt_reg, cnt_next;
    logic                           fin_reg, fin_next;
    logic                           ovalid_reg, ovalid_next;
    logic [erle_pkg::BYTE_W-1:0]    obyte_reg, obyte_next;
    logic                           olast_reg, olast_next;
    logic                           oeos_reg, oeos_next;

    erle_pkg::class_t cls;
    logic             out_free;
    logic             accept;

    erle_classify u_classify (
        .in_byte (s_tdata),
        .pending (pend_reg),
        .cls     (cls)
    );

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = oeos_reg;

    always_comb begin
        state_next  = state_reg;
        prev_next   = prev_reg;
        pend_next   = pend_reg;
        copy_next   = copy_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        ovalid_next = ovalid_reg && !m_tready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        oeos_next   = oeos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    fin_next  = s_tlast;
                    copy_next = prev_reg;
                    if (cls.escape) begin
                        pend_next = 1'b1;
                    end else begin
                        pend_next = 1'b0;
                        prev_next = s_tdata;
                    end
                    if (cls.pass) begin
                        ovalid_next = 1'b1;
                        obyte_next  = s_tdata;
                        olast_next  = !s_tlast;
                        oeos_next   = 1'b0;
                        state_next  = s_tlast ? ST_TERM : ST_IDLE;
                    end else if (cls.copies != '0) begin
                        ovalid_next = 1'b1;
                        obyte_next  = prev_reg;
                        olast_next  = (cls.copies == erle_pkg::COUNT_W'(1)) && !s_tlast;
                        oeos_next   = 1'b0;
                        cnt_next    = erle_pkg::REM_W'(cls.copies - erle_pkg::COUNT_W'(1));
                        if (cls.copies != erle_pkg::COUNT_W'(1)) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = s_tlast ? ST_TERM : ST_IDLE;
                        end
                    end else if (s_tlast) begin
                        ovalid_next = 1'b1;
                        obyte_next  = '0;
                        olast_next  = 1'b1;
                        oeos_next   = 1'b1;
                    end
                    if (s_tlast) begin
                        prev_next = '0;
                        pend_next = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    obyte_next  = copy_reg;
                    olast_next  = (cnt_reg == erle_pkg::REM_W'(1)) && !fin_reg;
                    oeos_next   = 1'b0;
                    cnt_next    = cnt_reg - erle_pkg::REM_W'(1);
                    if (cnt_reg == erle_pkg::REM_W'(1)) begin
                        state_next = fin_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    obyte_next  = '0;
                    olast_next  = 1'b1;
                    oeos_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            prev_reg   <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            prev_reg   <= prev_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_reg  <= copy_next;
        cnt_reg   <= cnt_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        oeos_reg  <= oeos_next;
    end

    // copy run never sits with an empty counter
    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (cnt_reg != '0))
        else $error("copy counter empty while emitting");

    // terminator always closes the run
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("terminator without tlast or with data");

    // a final input clears the escape state
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (!pend_reg && (prev_reg == '0)))
        else $error("state not cleared after final transfer");

    // no input taken while a run or terminator is pending
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while busy");

endmodule

// ===== tb/tb_escape_run_length_expander.sv =====
// testbench for the escape run-length expander: directed and random byte strings, scoreboard check
module tb_escape_run_length_expander;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic [erle_pkg::BYTE_W-1:0] out_byte;
        logic                        last_of_run;
        logic                        end_of_string;
    } expanded_t;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [erle_pkg::BYTE_W-1:0] s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [erle_pkg::BYTE_W-1:0] m_tdata;
    logic                        m_tlast;
    logic                        m_tuser;

    // predictor state
    logic [erle_pkg::BYTE_W-1:0] prev_raw    = '0;
    logic                        esc_pending = 1'b0;
    expanded_t                   pending_out[$];

    int errors       = 0;
    int cycles       = 0;
    int bytes_sent   = 0;
    int sender_mode  = 0;
    int receiver_mode = 0;

    escape_run_length_expander uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_out.size());
            $display("** escape_run_length_expander: FAILED **");
            $finish;
        end
    end

    // 0: no idling, 1: a gap drawn uniformly before each transfer, 2: mostly back to back with occasional gaps
    function automatic int draw_gap(input int mode);
        case (mode)
            1: return $urandom_range(0, 16);
            2: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
            default: return 0;
        endcase
    endfunction

    // ascii digit character for a value 0..9
    function automatic logic [erle_pkg::BYTE_W-1:0] digit_char(input int d);
        return erle_pkg::BYTE_W'(int'(erle_pkg::DIGIT_ZERO) + d);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic push_result(input logic [erle_pkg::BYTE_W-1:0] b, input logic last,
                               input logic eos);
        expanded_t r;
        r.out_byte      = b;
        r.last_of_run   = last;
        r.end_of_string = eos;
        pending_out.push_back(r);
    endtask

    // expected transfers caused by one accepted input byte
    task automatic expand_byte(input logic [erle_pkg::BYTE_W-1:0] b, input logic fin);
        int copies;
        int c;
        if (esc_pending) begin
            esc_pending = 1'b0;
            copies = 0;
            if (b >= erle_pkg::DIGIT_ONE && b <= erle_pkg::DIGIT_NINE)
                copies = int'(b - erle_pkg::DIGIT_ZERO) - 1;
            for (c = 0; c < copies; c++)
                push_result(prev_raw, !fin && (c == copies - 1), 1'b0);
            prev_raw = b;
        end else if (b == erle_pkg::ESC_CHAR) begin
            esc_pending = 1'b1;
        end else begin
            push_result(b, !fin, 1'b0);
            prev_raw = b;
        end
        if (fin) begin
            push_result('0, 1'b1, 1'b1);
            prev_raw    = '0;
            esc_pending = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [erle_pkg::BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = draw_gap(sender_mode);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        expand_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_out.size() != 0);
    endtask

    task automatic send_raw(input logic fin);
        logic [erle_pkg::BYTE_W-1:0] b;
        do b = erle_pkg::BYTE_W'($urandom_range(0, 255)); while (b == erle_pkg::ESC_CHAR);
        send_byte(b, fin);
    endtask

    // string of raw bytes and escape pairs, optionally closed by a lone escape, tlast on the closing byte
    task automatic send_string(input int tokens, input bit end_on_escape);
        int k;
        bit last_tok;
        for (k = 0; k < tokens; k++) begin
            last_tok = (k == tokens - 1);
            if (last_tok && end_on_escape) begin
                send_byte(erle_pkg::ESC_CHAR, 1'b1);
            end else if ($urandom_range(0, 9) < 3) begin
                send_byte(erle_pkg::ESC_CHAR, 1'b0);
                send_byte(digit_char($urandom_range(1, 9)), last_tok);
            end else begin
                send_raw(last_tok);
            end
        end
    endtask

    task automatic test_directed();
        sender_mode   = 0;
        receiver_mode = 0;
        // leading escape repeats the reset value
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(digit_char(5), 1'b0);
        // zero byte and all-ones byte as raw data
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // longest run
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(erle_pkg::DIGIT_NINE, 1'b0);
        // count of one gives nothing
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(erle_pkg::DIGIT_ONE, 1'b0);
        // non-digit counts close the escape and become the previous raw byte
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(erle_pkg::DIGIT_ZERO, 1'b0);
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(digit_char(3), 1'b0);
        // plain byte closing a string
        send_byte(8'h41, 1'b1);
        // escape as the final byte
        send_byte(erle_pkg::ESC_CHAR, 1'b1);
        // run on the final byte
        send_byte(8'h42, 1'b0);
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(erle_pkg::DIGIT_NINE, 1'b1);
        // state cleared after the terminator
        send_byte(erle_pkg::ESC_CHAR, 1'b0);
        send_byte(digit_char(2), 1'b1);
        wait_drained();
    endtask

    task automatic test_strings(input int n_bytes);
        int stop_at;
        int n;
        stop_at = bytes_sent + n_bytes;
        n = 0;
        while (bytes_sent < stop_at) begin
            sender_mode   = $urandom_range(0, 2);
            receiver_mode = $urandom_range(0, 2);
            send_string($urandom_range(1, 12), $urandom_range(0, 7) == 0);
            n++;
            if (n % 5 == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // arbitrary bytes: stray escapes, digit neighbors, tlast anywhere
    task automatic test_noise(input int n_bytes);
        int k;
        logic [erle_pkg::BYTE_W-1:0] b;
        for (k = 0; k < n_bytes; k++) begin
            if (k % 20 == 0) begin
                sender_mode   = $urandom_range(0, 2);
                receiver_mode = $urandom_range(0, 2);
            end
            case ($urandom_range(0, 4))
                0: b = erle_pkg::ESC_CHAR;
                1: b = digit_char($urandom_range(0, 9));
                2: b = ($urandom_range(0, 1) != 0) ? erle_pkg::DIGIT_ZERO - 8'd1
                                                   : erle_pkg::DIGIT_NINE + 8'd1;
                default: b = erle_pkg::BYTE_W'($urandom_range(0, 255));
            endcase
            send_byte(b, $urandom_range(0, 7) == 0);
        end
        send_raw(1'b1);
        wait_drained();
    endtask

    always @(posedge aclk) begin
        expanded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                flag_error($sformatf("unexpected transfer data %h last %b user %b",
                                     m_tdata, m_tlast, m_tuser));
            end else begin
                want = pending_out.pop_front();
                if (m_tdata !== want.out_byte || m_tlast !== want.last_of_run ||
                    m_tuser !== want.end_of_string)
                    flag_error($sformatf("data %h/%h last %b/%b user %b/%b (exp/got)",
                                         want.out_byte, m_tdata, want.last_of_run, m_tlast,
                                         want.end_of_string, m_tuser));
            end
        end
    end

    // result side backpressure
    initial begin
        int gap;
        forever begin
            gap = draw_gap(receiver_mode);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_strings(180);
        test_noise(60);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("** escape_run_length_expander: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** escape_run_length_expander: FAILED **");
        end
        $finish;
    end

endmodule
